// ----- rtl/wdrt_pkg.sv -----
// Package for the windowed damage rate tracker.
// Holds widths, ring depth, command codes and the packed item types.
// No dependencies.
package wdrt_pkg;

  localparam int unsigned EventSlots = 8;  // ring depth, 2 to 8
  localparam int unsigned IdxW       = (EventSlots > 2) ? $clog2(EventSlots) : 1;

  localparam int unsigned HpW     = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned WindowW = 16;
  localparam int unsigned SumW    = 19;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CmdW    = 2;

  localparam logic [WindowW-1:0] WindowReset = WindowW'(1000);

  localparam logic [IdxW-1:0] LastSlot = IdxW'(EventSlots - 1);

  typedef enum logic [CmdW-1:0] {
    CMD_HP_REPORT     = 2'd0,
    CMD_DAMAGE_NOTICE = 2'd1,
    CMD_TIME_TICK     = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [TimeW-1:0] time_ms;
    logic [HpW-1:0]   hp_value;
    logic [CmdW-1:0]  cmd;
  } item_t;

  typedef struct packed {
    logic              event_logged;
    logic [CountW-1:0] event_count;
    logic [SumW-1:0]   damage_sum;
  } result_t;

  function automatic logic [IdxW-1:0] slot_after(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] nxt;
    nxt = (idx == LastSlot) ? '0 : idx + IdxW'(1);
    return nxt;
  endfunction

endpackage

// ----- rtl/wdrt_tracker.sv -----
// Tracker state and its combinational next-state update for one item.
// Holds hit points, the event ring and the running sum.
// Depends on wdrt_pkg.
module wdrt_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  wdrt_pkg::item_t               item_i,
  input  logic [wdrt_pkg::WindowW-1:0]  window_i,
  output wdrt_pkg::result_t             result_o
);

  logic [wdrt_pkg::HpW-1:0]   prev_hp_q, prev_hp_d;
  logic [wdrt_pkg::HpW-1:0]   cur_hp_q, cur_hp_d;
  logic [wdrt_pkg::IdxW-1:0]  oldest_q, oldest_d;
  logic [wdrt_pkg::IdxW-1:0]  next_q, next_d;
  logic [wdrt_pkg::SumW-1:0]  sum_q, sum_d;

  logic [wdrt_pkg::HpW-1:0]   ev_dmg_q  [wdrt_pkg::EventSlots];
  logic [wdrt_pkg::TimeW-1:0] ev_time_q [wdrt_pkg::EventSlots];

  logic                       wr_en;
  logic [wdrt_pkg::HpW-1:0]   dmg;
  logic [wdrt_pkg::HpW-1:0]   oldest_dmg;
  logic [wdrt_pkg::TimeW-1:0] age;
  logic [wdrt_pkg::IdxW-1:0]  next_adv;
  logic                       logged;
  logic [wdrt_pkg::IdxW:0]    span;

  assign dmg        = prev_hp_q - item_i.hp_value;
  assign oldest_dmg = ev_dmg_q[oldest_q];
  assign age        = item_i.time_ms - ev_time_q[oldest_q];
  assign next_adv   = wdrt_pkg::slot_after(next_q);

  always_comb begin
    prev_hp_d = prev_hp_q;
    cur_hp_d  = cur_hp_q;
    oldest_d  = oldest_q;
    next_d    = next_q;
    sum_d     = sum_q;
    wr_en     = 1'b0;
    logged    = 1'b0;
    case (item_i.cmd)
      wdrt_pkg::CMD_HP_REPORT: begin
        cur_hp_d = item_i.hp_value;
        if (prev_hp_q > item_i.hp_value) begin
          wr_en     = 1'b1;
          logged    = 1'b1;
          prev_hp_d = item_i.hp_value;
          next_d    = next_adv;
          // drop the oldest event when the ring would wrap onto it
          if (next_adv == oldest_q) begin
            oldest_d = wdrt_pkg::slot_after(oldest_q);
            sum_d    = sum_q - wdrt_pkg::SumW'(oldest_dmg) + wdrt_pkg::SumW'(dmg);
          end else begin
            sum_d    = sum_q + wdrt_pkg::SumW'(dmg);
          end
        end
      end
      wdrt_pkg::CMD_DAMAGE_NOTICE: begin
        prev_hp_d = cur_hp_q;
      end
      wdrt_pkg::CMD_TIME_TICK: begin
        if (oldest_q != next_q &&
            age > {{(wdrt_pkg::TimeW - wdrt_pkg::WindowW){1'b0}}, window_i}) begin
          oldest_d = wdrt_pkg::slot_after(oldest_q);
          sum_d    = sum_q - wdrt_pkg::SumW'(oldest_dmg);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (next_d >= oldest_d) begin
      span = {1'b0, next_d} - {1'b0, oldest_d};
    end else begin
      span = {1'b0, next_d} + (wdrt_pkg::IdxW + 1)'(wdrt_pkg::EventSlots) - {1'b0, oldest_d};
    end
  end

  assign result_o.damage_sum   = sum_d;
  assign result_o.event_count  = wdrt_pkg::CountW'(span);
  assign result_o.event_logged = logged;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_hp_q <= '0;
      cur_hp_q  <= '0;
      oldest_q  <= '0;
      next_q    <= '0;
      sum_q     <= '0;
    end else if (en_i) begin
      prev_hp_q <= prev_hp_d;
      cur_hp_q  <= cur_hp_d;
      oldest_q  <= oldest_d;
      next_q    <= next_d;
      sum_q     <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && wr_en) begin
      ev_dmg_q[next_q]  <= dmg;
      ev_time_q[next_q] <= item_i.time_ms;
    end
  end

`ifndef SYNTHESIS
  a_logged_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && logged |=> oldest_q != next_q)
    else $error("ring empty after logging an event");

  a_notice_keeps_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.cmd == wdrt_pkg::CMD_DAMAGE_NOTICE |=> $stable(sum_q) && $stable(next_q))
    else $error("damage notice changed the ring or the sum");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= wdrt_pkg::LastSlot && next_q <= wdrt_pkg::LastSlot)
    else $error("ring pointer beyond last slot");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(sum_q) && $stable(oldest_q) && $stable(prev_hp_q))
    else $error("state moved without an item");
`endif

endmodule

// ----- rtl/windowed_damage_rate_tracker_top.sv -----
// Top level of the windowed damage rate tracker.
// Input register, result register and window register around wdrt_tracker.
// Depends on wdrt_pkg and wdrt_tracker.

// Accepts one item per clock while not stalled and returns one result per
// item, from the input register through the result register. The rate is
// one item per cycle, set by the combinational update of the tracker state
// (compare, one add and subtract, ring pointer advance). Backpressure on the
// result side stalls the input only once both registers hold data. The
// window register resets to 1000 ms and must be written while the block is
// idle; the configuration channel is always ready.
module windowed_damage_rate_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] hp_value, [47:16] time_ms
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [18:0] damage_sum, [21:19] event_count, zero fill
  output logic        m_axis_tuser,   // [0] event_logged

  input  logic        cfg_wvalid_i,
  output logic        cfg_wready_o,
  input  logic [15:0] cfg_wdata_i
);

  logic                                in_valid_q;
  wdrt_pkg::item_t                     in_item_q;
  logic                                out_valid_q;
  wdrt_pkg::result_t                   out_res_q;
  logic [wdrt_pkg::WindowW-1:0]        window_q;
  wdrt_pkg::result_t                   res;
  logic                                advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_wready_o  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= wdrt_pkg::WindowReset;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wvalid_i) begin
        window_q <= cfg_wdata_i;
      end
    end
  end

  // capture a transaction, hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.cmd      <= s_axis_tuser;
      in_item_q.hp_value <= s_axis_tdata[15:0];
      in_item_q.time_ms  <= s_axis_tdata[47:16];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  wdrt_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_item_q),
    .window_i (window_q),
    .result_o (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.event_count, out_res_q.damage_sum};
  assign m_axis_tuser  = out_res_q.event_logged;

endmodule
